@@ rtl/core/utf16_to_utf8_transcoder_assert.svh @@
// Assertion macros shared by the transcoder RTL.
`ifndef UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define U16U8_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define U16U8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/u16u8_pkg.sv @@
// Shared types, constants and byte encoder for the UTF-16 to UTF-8 transcoder.
package u16u8_pkg;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [5:0]  HIGH_SUR_TAG   = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0]  LOW_SUR_TAG    = 6'b110111;  // 0xDC00..0xDFFF
  localparam logic [10:0] SUPP_HI_BIAS   = 11'h040;    // 0x10000 >> 10

  // Bytes of U+FFFD
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // Encoded length codes
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_ONE  = 3'd1;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THR  = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // One unit of work for the byte serializer
  typedef struct packed {
    logic        pre_repl;  // emit U+FFFD for a dropped high surrogate first
    logic [2:0]  main_len;  // bytes of the main scalar, LEN_NONE if none
    logic [20:0] cp;        // main scalar value
    logic        last;      // unit closes the string
  } job_t;

  // Byte m of the UTF-8 form of cp, whose length is len
  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [2:0] len,
                                          input logic [1:0] m);
    logic [7:0] b;
    b = 8'h00;
    unique case (len)
      LEN_ONE: b = {1'b0, cp[6:0]};
      LEN_TWO: b = (m == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      LEN_THR: begin
        unique case (m)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      LEN_FOUR: begin
        unique case (m)
          2'd0: b = {5'b11110, cp[20:18]};
          2'd1: b = {2'b10, cp[17:12]};
          2'd2: b = {2'b10, cp[11:6]};
          2'd3: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/u16u8_if.sv @@
// Valid/ready channel interfaces for UTF-16 units in and UTF-8 bytes out.
interface u16u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        final_unit;

  modport source (output valid, output code_unit, output final_unit, input ready);
  modport sink   (input valid, input code_unit, input final_unit, output ready);
endinterface

interface u16u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] utf8_byte;
  logic       run_end;
  logic       string_end;

  modport source (output valid, output utf8_byte, output run_end, output string_end,
                  input ready);
  modport sink   (input valid, input utf8_byte, input run_end, input string_end,
                  output ready);
endinterface

@@ rtl/core/u16u8_front.sv @@
// Front end: accepts code units, pairs surrogates and builds serializer jobs.
module u16u8_front (
  input  logic                clk,
  input  logic                rst_n,
  u16u8_in_if.sink            in_bus,
  input  logic                q_full,
  output logic                push,
  output u16u8_pkg::job_t     push_job
);

  logic        held_valid_r, held_valid_nxt;
  logic [9:0]  held_bits_r, held_bits_nxt;
  logic        is_hi, is_lo, accept;
  logic [20:0] alone_cp;
  logic [2:0]  alone_len;
  u16u8_pkg::job_t job;

  assign in_bus.ready = !q_full;
  assign accept       = in_bus.valid && !q_full;

  assign is_hi = (in_bus.code_unit[15:10] == u16u8_pkg::HIGH_SUR_TAG);
  assign is_lo = (in_bus.code_unit[15:10] == u16u8_pkg::LOW_SUR_TAG);

  // Scalar for the unit taken on its own
  always_comb begin
    alone_cp = {5'd0, in_bus.code_unit};
    if (is_lo || is_hi) begin
      alone_cp = u16u8_pkg::REPLACEMENT_CP;
    end
    if (is_hi && !in_bus.final_unit) begin
      alone_len = u16u8_pkg::LEN_NONE;
    end else if (alone_cp < 21'h80) begin
      alone_len = u16u8_pkg::LEN_ONE;
    end else if (alone_cp < 21'h800) begin
      alone_len = u16u8_pkg::LEN_TWO;
    end else begin
      alone_len = u16u8_pkg::LEN_THR;
    end
  end

  // Classification and surrogate hold state
  always_comb begin
    job.last       = in_bus.final_unit;
    job.pre_repl   = held_valid_r;
    job.main_len   = alone_len;
    job.cp         = alone_cp;
    held_valid_nxt = held_valid_r;
    held_bits_nxt  = held_bits_r;
    if (accept) begin
      if (held_valid_r && is_lo) begin
        job.pre_repl  = 1'b0;
        job.main_len  = u16u8_pkg::LEN_FOUR;
        job.cp        = {11'(held_bits_r) + u16u8_pkg::SUPP_HI_BIAS,
                         in_bus.code_unit[9:0]};
        held_valid_nxt = 1'b0;
        held_bits_nxt  = '0;
      end else if (is_hi && !in_bus.final_unit) begin
        held_valid_nxt = 1'b1;
        held_bits_nxt  = in_bus.code_unit[9:0];
      end else begin
        held_valid_nxt = 1'b0;
        held_bits_nxt  = '0;
      end
    end
  end

  assign push     = accept && (job.pre_repl || (job.main_len != u16u8_pkg::LEN_NONE));
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_bits_r  <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_bits_r  <= held_bits_nxt;
    end
  end

endmodule

@@ rtl/core/u16u8_queue.sv @@
// Small job queue between the front end and the byte serializer.
`include "utf16_to_utf8_transcoder_assert.svh"
module u16u8_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  u16u8_pkg::job_t     push_job,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output u16u8_pkg::job_t     head_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u16u8_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `U16U8_ASSERT_NOW(a_q_no_overflow, push, !full, "queue written while full")
  `U16U8_ASSERT_NOW(a_q_no_underflow, pop, head_valid, "queue read while empty")
  `U16U8_ASSERT_NOW(a_q_count_range, 1'b1, count_r <= CNT_W'(DEPTH), "queue count out of range")

endmodule

@@ rtl/core/u16u8_back.sv @@
// Back end: serializes each job into UTF-8 bytes, one beat per cycle while the output is not stalled.
`include "utf16_to_utf8_transcoder_assert.svh"
module u16u8_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  u16u8_pkg::job_t     head_job,
  output logic                pop,
  u16u8_out_if.source         out_bus
);

  u16u8_pkg::job_t cur_r, cur_nxt;
  logic            cur_valid_r, cur_valid_nxt;
  logic [2:0]      step_r, step_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic            run_end_r, run_end_nxt;
  logic            str_end_r, str_end_nxt;
  logic [2:0]      total, main_idx;
  logic            adv, last_byte;
  logic [7:0]      cur_byte;

  // Position within the job
  assign total     = (cur_r.pre_repl ? 3'd3 : 3'd0) + cur_r.main_len;
  assign last_byte = (step_r == total - 3'd1);
  assign main_idx  = cur_r.pre_repl ? step_r - 3'd3 : step_r;
  assign adv       = !out_valid_r || out_bus.ready;

  // Byte at the current position
  always_comb begin
    if (cur_r.pre_repl && step_r < 3'd3) begin
      unique case (step_r[1:0])
        2'd0:    cur_byte = u16u8_pkg::REPL_B0;
        2'd1:    cur_byte = u16u8_pkg::REPL_B1;
        default: cur_byte = u16u8_pkg::REPL_B2;
      endcase
    end else begin
      cur_byte = u16u8_pkg::enc_byte(cur_r.cp, cur_r.main_len, main_idx[1:0]);
    end
  end

  assign pop = head_valid && (!cur_valid_r || (adv && last_byte));

  // Serializer and output register
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    run_end_nxt   = run_end_r;
    str_end_nxt   = str_end_r;
    if (adv) begin
      out_valid_nxt = cur_valid_r;
      byte_nxt      = cur_byte;
      run_end_nxt   = last_byte;
      str_end_nxt   = last_byte && cur_r.last;
      if (cur_valid_r) begin
        if (last_byte) begin
          cur_valid_nxt = 1'b0;
          step_nxt      = '0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
    end
    if (pop) begin
      cur_nxt       = head_job;
      cur_valid_nxt = 1'b1;
      step_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    byte_r    <= byte_nxt;
    run_end_r <= run_end_nxt;
    str_end_r <= str_end_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.utf8_byte  = byte_r;
  assign out_bus.run_end    = run_end_r;
  assign out_bus.string_end = str_end_r;

  `U16U8_ASSERT_NOW(a_step_in_job, cur_valid_r, step_r < total, "step past end of job")
  `U16U8_ASSERT_NOW(a_str_end_run_end, out_valid_r && str_end_r, run_end_r,
                    "string end without run end")
  `U16U8_ASSERT_NEXT(a_pop_loads, pop, cur_valid_r && (step_r == 3'd0),
                     "popped job not loaded at first byte")

endmodule

@@ rtl/core/utf16_to_utf8_transcoder.sv @@
// UTF-16 to UTF-8 transcoder top level.
// Takes one UTF-16 code unit per beat and emits UTF-8 one byte per beat. The bytes a
// unit causes: 1 to 3 for a BMP character, 4 for a completed surrogate pair (on
// the low half), up to 6 when a held high surrogate is dropped as U+FFFD ahead
// of the new unit, and none for a high surrogate that is held. The byte
// serializer in the back end, at one byte per cycle while the output is not
// stalled, sets the sustained rate; the front end takes a new unit every
// cycle while the job queue (QUEUE_DEPTH entries) has room, so input and output
// stall independently. run_end marks the last byte a unit causes, string_end
// the last byte of a unit flagged final_unit. No clearing pass after reset.
module utf16_to_utf8_transcoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  u16u8_in_if.sink      in_bus,
  u16u8_out_if.source   out_bus
);

  logic            q_push, q_full, q_pop, q_head_valid;
  u16u8_pkg::job_t q_push_job, q_head_job;

  u16u8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .q_full   (q_full),
    .push     (q_push),
    .push_job (q_push_job)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .out_bus    (out_bus)
  );

endmodule

@@ tb/utf8_stream_check.sv @@
// Predicts the UTF-8 byte stream from accepted UTF-16 units and checks the output channel.
`timescale 1ns / 1ps

module utf8_stream_check (
  input  logic   clk,
  input  logic   rst_n,
  u16u8_in_if    in_mon,
  u16u8_out_if   out_mon,
  output int     fail_total,
  output int     beats_pending
);

  localparam logic [5:0]  HI_SUR_PREFIX = 6'b110110;
  localparam logic [5:0]  LO_SUR_PREFIX = 6'b110111;
  localparam logic [20:0] SUPP_BASE     = 21'h010000;
  localparam logic [20:0] REPLACEMENT   = 21'h00FFFD;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       run_end;
    logic       string_end;
  } utf8_beat_t;

  utf8_beat_t expected_beats[$];
  logic [7:0] unit_bytes[$];

  // surrogate held between units
  logic [9:0] held_hi;
  logic       held_on;
  int         fails;

  // UTF-8 form of one scalar value, appended to the bytes of the current unit
  function automatic void push_scalar(input logic [20:0] cp);
    if (cp < 21'h80) begin
      unit_bytes.push_back({1'b0, cp[6:0]});
    end else if (cp < 21'h800) begin
      unit_bytes.push_back({3'b110, cp[10:6]});
      unit_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < SUPP_BASE) begin
      unit_bytes.push_back({4'b1110, cp[15:12]});
      unit_bytes.push_back({2'b10, cp[11:6]});
      unit_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      unit_bytes.push_back({5'b11110, cp[20:18]});
      unit_bytes.push_back({2'b10, cp[17:12]});
      unit_bytes.push_back({2'b10, cp[11:6]});
      unit_bytes.push_back({2'b10, cp[5:0]});
    end
  endfunction

  // expected beats for one accepted code unit
  function automatic void predict_unit(input logic [15:0] cu, input logic fin);
    logic       is_hi;
    logic       is_lo;
    logic       paired;
    utf8_beat_t beat;
    is_hi  = (cu[15:10] == HI_SUR_PREFIX);
    is_lo  = (cu[15:10] == LO_SUR_PREFIX);
    paired = 1'b0;
    unit_bytes.delete();

    // a held high surrogate either completes a pair or turns into U+FFFD
    if (held_on) begin
      held_on = 1'b0;
      if (is_lo) begin
        push_scalar(SUPP_BASE + {1'b0, held_hi, cu[9:0]});
        paired = 1'b1;
      end else begin
        push_scalar(REPLACEMENT);
      end
      held_hi = '0;
    end

    if (!paired) begin
      if (is_hi) begin
        if (fin) begin
          push_scalar(REPLACEMENT);
        end else begin
          held_hi = cu[9:0];
          held_on = 1'b1;
        end
      end else if (is_lo) begin
        push_scalar(REPLACEMENT);
      end else begin
        push_scalar({5'd0, cu});
      end
    end

    foreach (unit_bytes[k]) begin
      beat.utf8_byte  = unit_bytes[k];
      beat.run_end    = (k == unit_bytes.size() - 1);
      beat.string_end = beat.run_end && fin;
      expected_beats.push_back(beat);
    end
  endfunction

  // input beats feed the predictor, output beats are checked in order
  always @(posedge clk) begin
    utf8_beat_t want;
    if (!rst_n) begin
      held_on = 1'b0;
      held_hi = '0;
      expected_beats.delete();
      fails = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        predict_unit(in_mon.code_unit, in_mon.final_unit);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected output beat: utf8_byte %h run_end %b string_end %b",
                 out_mon.utf8_byte, out_mon.run_end, out_mon.string_end);
          fails++;
        end else begin
          want = expected_beats.pop_front();
          if (out_mon.utf8_byte !== want.utf8_byte) begin
            $error("utf8_byte: expected %h, got %h", want.utf8_byte, out_mon.utf8_byte);
            fails++;
          end
          if (out_mon.run_end !== want.run_end) begin
            $error("run_end: expected %b, got %b", want.run_end, out_mon.run_end);
            fails++;
          end
          if (out_mon.string_end !== want.string_end) begin
            $error("string_end: expected %b, got %b", want.string_end, out_mon.string_end);
            fails++;
          end
        end
      end
    end
    fail_total    <= fails;
    beats_pending <= expected_beats.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the transcoder testbench: clock, reset, stimulus, backpressure and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_UNITS = 425;
  localparam int CALM_TAIL    = 90;

  // {final_unit, code_unit}: ranges, pairs and the surrogate error cases
  localparam logic [16:0] DIRECTED_UNITS [25] = '{
    17'h0_0000, 17'h0_007F, 17'h0_0080, 17'h0_07FF, 17'h0_0800, 17'h0_D7FF,
    17'h0_E000, 17'h1_FFFF,
    17'h0_D800, 17'h0_DC00, 17'h0_DBFF, 17'h1_DFFF,
    17'h0_D800, 17'h0_0041,
    17'h0_D834, 17'h0_D835, 17'h0_DD1E,
    17'h0_DABC, 17'h0_0800,
    17'h0_DC00,
    17'h1_DBFF,
    17'h0_D800, 17'h1_DB00,
    17'h0_DB7F, 17'h1_07FF
  };

  logic clk;
  logic rst_n;
  logic gaps_on;
  logic stall_on;
  int   random_units;
  int   fail_total;
  int   beats_pending;

  u16u8_in_if  in_ch ();
  u16u8_out_if out_ch ();

  utf16_to_utf8_transcoder uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  utf8_stream_check scb (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_total    (fail_total),
    .beats_pending (beats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #5ms;
    $display("utf16_to_utf8_transcoder regression: fail");
    $finish;
  end

  // output backpressure in bursts, only while stall_on is set
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // one input beat, optionally after a gap; returns at the falling edge after acceptance
  task automatic send_unit(input logic [15:0] cu, input logic fin);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.code_unit  <= cu;
    in_ch.final_unit <= fin;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // a string of 1 to 8 units, mostly valid text with some broken surrogates
  task automatic send_random_string();
    int          len;
    int          i;
    int          pick;
    logic [15:0] cu;
    len = $urandom_range(1, 8);
    i = 0;
    while (i < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 30 && i + 1 < len) begin
        send_unit(16'hD800 | 16'($urandom_range(0, 1023)), 1'b0);
        send_unit(16'hDC00 | 16'($urandom_range(0, 1023)), i + 2 == len);
        i += 2;
      end else begin
        if (pick < 45) begin
          cu = 16'($urandom_range(0, 16'h007F));
        end else if (pick < 60) begin
          cu = 16'($urandom_range(16'h0080, 16'h07FF));
        end else if (pick < 72) begin
          cu = $urandom_range(0, 1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                    : 16'($urandom_range(16'hE000, 16'hFFFF));
        end else if (pick < 86) begin
          cu = 16'($urandom);
        end else if (pick < 93) begin
          cu = 16'($urandom_range(16'hD800, 16'hDBFF));
        end else begin
          cu = 16'($urandom_range(16'hDC00, 16'hDFFF));
        end
        send_unit(cu, i + 1 == len);
        i++;
      end
    end
    random_units += len;
  endtask

  // stimulus and verdict
  initial begin
    rst_n            = 1'b0;
    gaps_on          = 1'b1;
    stall_on         = 1'b1;
    random_units     = 0;
    in_ch.valid      = 1'b0;
    in_ch.code_unit  = '0;
    in_ch.final_unit = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_UNITS[k]) begin
      send_unit(DIRECTED_UNITS[k][15:0], DIRECTED_UNITS[k][16]);
    end

    // random strings; idle mode changes per string, none in the tail
    while (random_units < RANDOM_UNITS) begin
      if (random_units >= RANDOM_UNITS - CALM_TAIL) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end else begin
        gaps_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      send_random_string();
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (beats_pending != 0);
    repeat (20) @(posedge clk);

    if (fail_total == 0 && beats_pending == 0) begin
      $display("utf16_to_utf8_transcoder regression: pass");
    end else begin
      $display("utf16_to_utf8_transcoder regression: fail");
    end
    $finish;
  end

endmodule
